FILE: hw/rtl/kvt_pkg.sv
package kvt_pkg;

    localparam int KEY_BITS   = 20;
    localparam int VALUE_BITS = 20;
    localparam int OPCODE_W   = 2;

    localparam logic [OPCODE_W-1:0] OP_PUT    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_GET    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [OPCODE_W-1:0]   opcode;
        logic [KEY_BITS-1:0]   lookup_key;
        logic [VALUE_BITS-1:0] put_value;
    } kvt_req_t;

    typedef struct packed {
        logic                  found;
        logic [VALUE_BITS-1:0] read_value;
        logic                  status;
    } kvt_resp_t;

    // One table slot as it is kept in the RAM.
    typedef struct packed {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } kvt_entry_t;

    localparam int ENTRY_W = $bits(kvt_entry_t);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } kvt_state_t;

endpackage

FILE: hw/rtl/kvt_ram.sv
module kvt_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/key_value_table.sv
// Bounded key-value table with CAPACITY slots held in one single-port-write,
// registered-read RAM; each slot stores a valid flag, a key and a value.
// Every operation (put, get, remove) walks the slots in order, one RAM read
// per cycle, and stops at the slot holding the key or after the last slot.
// An operation first takes the transfer, then scans the slots, including
// the read latency, and last writes the slot back and loads the result
// register, which waits while the output register still holds a result.
// A put of a new key goes to the lowest free slot; if none is free it is
// dropped and reported with status 1. After reset the block clears every
// slot's valid flag and holds s_ready low during that pass. A finished
// result waits in the output register while the next operation is taken
// and scanned.
module key_value_table
    import kvt_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  kvt_req_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output kvt_resp_t m_data
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    kvt_state_t state_reg, state_next;

    logic [IDX_W-1:0]      clr_idx_reg;
    logic [IDX_W-1:0]      iss_reg;
    logic                  iss_done_reg;
    logic                  rd_pend_reg;
    logic [IDX_W-1:0]      chk_idx_reg;
    logic                  hit_reg;
    logic [IDX_W-1:0]      hit_idx_reg;
    logic [VALUE_BITS-1:0] hit_value_reg;
    logic                  free_seen_reg;
    logic [IDX_W-1:0]      free_idx_reg;
    kvt_req_t              req_reg;
    logic                  m_valid_reg;
    kvt_resp_t             m_data_reg;

    logic                  rd_en;
    logic [ENTRY_W-1:0]    rd_data;
    kvt_entry_t            rd_entry;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    kvt_entry_t            wr_entry;
    logic                  load_out;
    kvt_resp_t             resp;

    logic cur_match;
    logic cur_free;
    logic last_chk;
    logic out_free;
    logic accept;
    logic op_known;

    kvt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_slots (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (iss_reg),
        .rd_data (rd_data)
    );

    assign rd_entry  = kvt_entry_t'(rd_data);
    assign cur_match = rd_pend_reg && rd_entry.valid && (rd_entry.key == req_reg.lookup_key);
    assign cur_free  = rd_pend_reg && !rd_entry.valid;
    assign last_chk  = rd_pend_reg && (chk_idx_reg == LAST_IDX);
    assign out_free  = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign op_known  = (req_reg.opcode == OP_PUT) || (req_reg.opcode == OP_GET)
                       || (req_reg.opcode == OP_REMOVE);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_idx_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cur_match || last_chk) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs: handshake, RAM control and the result.
    always_comb begin
        s_ready  = 1'b0;
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = hit_idx_reg;
        wr_entry = '0;
        load_out = 1'b0;

        resp.found      = hit_reg && op_known;
        resp.read_value = (req_reg.opcode == OP_GET && hit_reg) ? hit_value_reg : '0;
        resp.status     = (req_reg.opcode == OP_PUT && !hit_reg && !free_seen_reg)
                          ? STATUS_FULL : STATUS_OK;

        unique case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_idx_reg;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_SCAN: begin
                rd_en = !iss_done_reg;
            end
            ST_FINISH: begin
                load_out = out_free;
                case (req_reg.opcode)
                    OP_PUT: begin
                        wr_en          = out_free && (hit_reg || free_seen_reg);
                        wr_addr        = hit_reg ? hit_idx_reg : free_idx_reg;
                        wr_entry.valid = 1'b1;
                        wr_entry.key   = req_reg.lookup_key;
                        wr_entry.value = req_reg.put_value;
                    end
                    OP_REMOVE: begin
                        wr_en          = out_free && hit_reg;
                        wr_entry.valid = 1'b0;
                        wr_entry.key   = req_reg.lookup_key;
                        wr_entry.value = hit_value_reg;
                    end
                    default: begin
                        wr_en = 1'b0;
                    end
                endcase
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_en;
            if (state_reg == ST_CLEAR) begin
                clr_idx_reg <= clr_idx_reg + IDX_W'(1);
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Scan bookkeeping; the read issued at iss_reg returns in the next cycle
    // and is checked against chk_idx_reg.
    always_ff @(posedge aclk) begin
        chk_idx_reg <= iss_reg;
        if (accept) begin
            req_reg       <= s_data;
            iss_reg       <= '0;
            iss_done_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            free_seen_reg <= 1'b0;
        end else if (state_reg == ST_SCAN) begin
            if (rd_en) begin
                iss_reg      <= iss_reg + IDX_W'(1);
                iss_done_reg <= (iss_reg == LAST_IDX);
            end
            if (cur_match) begin
                hit_reg       <= 1'b1;
                hit_idx_reg   <= chk_idx_reg;
                hit_value_reg <= rd_entry.value;
            end
            if (cur_free && !free_seen_reg) begin
                free_seen_reg <= 1'b1;
                free_idx_reg  <= chk_idx_reg;
            end
        end
        if (load_out) begin
            m_data_reg <= resp;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
